@@ rtl/core/kls_pkg.sv @@
// ----------------------------------------------------------------------------
// kls_pkg
// Shared types, token codes and keyword tables for the keyword lexer stream.
// ----------------------------------------------------------------------------
package kls_pkg;

   // Offset and length counters saturate at 2^OFFSET_BITS - 1
   localparam int OFFSET_BITS = 16;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   // Width of the start and length fields of a result word
   localparam int FIELD_BITS = 16;

   // Front-to-back token queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // Tokens that one source byte can produce at most
   localparam int BUNDLE_SLOTS = 3;

   // Keyword table
   localparam int KW_COUNT = 7;

   typedef enum logic [4:0] {
      TK_INTEGER  = 5'd0,
      TK_BEGIN    = 5'd1,
      TK_END_KW   = 5'd2,
      TK_IF       = 5'd3,
      TK_THEN     = 5'd4,
      TK_ELSE     = 5'd5,
      TK_FUNCTION = 5'd6,
      TK_SEMI     = 5'd7,
      TK_LPAREN   = 5'd8,
      TK_RPAREN   = 5'd9,
      TK_LE       = 5'd10,
      TK_MINUS    = 5'd11,
      TK_STAR     = 5'd12,
      TK_ASSIGN   = 5'd13,
      TK_IDENT    = 5'd14,
      TK_LITERAL  = 5'd15,
      TK_EOF      = 5'd16,
      TK_ERROR    = 5'd17
   } token_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_BAD_INT = 2'd1,
      ERR_UNKNOWN = 2'd2
   } error_code_type;

   // Keyword spellings, one character per slot, zero padded
   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{"i", "n", "t", "e", "g", "e", "r", 8'h00},
      '{"b", "e", "g", "i", "n", 8'h00, 8'h00, 8'h00},
      '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "u", "n", "c", "t", "i", "o", "n"}
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd7, 4'd5, 4'd3, 4'd2, 4'd4, 4'd4, 4'd8
   };

   // Input word
   typedef struct packed {
      logic [7:0] source_byte;
      logic       last_byte;
   } req_type;

   // Result word
   typedef struct packed {
      logic [4:0]            token_kind;
      logic [1:0]            error_code;
      logic [FIELD_BITS-1:0] token_start;
      logic [FIELD_BITS-1:0] token_length;
      logic                  end_of_run;
   } rsp_type;

   // All tokens produced by one source byte; slot 0 goes out first
   typedef struct packed {
      logic [1:0]                   count;
      rsp_type [BUNDLE_SLOTS-1:0]   tok;
   } bundle_type;

   // Queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/core/kls_front.sv @@
// ----------------------------------------------------------------------------
// kls_front
// Lexer state machine: classifies one source byte per cycle unless the
// queue is full, and hands the tokens it causes to the queue as one bundle.
// ----------------------------------------------------------------------------
module kls_front import kls_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             push_valid,
   output bundle_type       push_data
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LT,
      MODE_COLON,
      MODE_ZERO,
      MODE_NUMBER,
      MODE_IDENT,
      MODE_ERROR,
      MODE_DONE
   } mode_type;

   typedef logic [OFFSET_BITS-1:0] offset_type;

   typedef struct packed {
      mode_type            mode;
      offset_type          start;
      offset_type          len;
      logic [KW_COUNT-1:0] alive;
   } lex_state_type;

   typedef struct packed {
      lex_state_type st;
      logic [1:0]    count;
      rsp_type       tok1;
      rsp_type       tok0;
   } feed_type;

   localparam lex_state_type RESET_STATE = '{
      mode:  MODE_IDLE,
      start: '0,
      len:   '0,
      alive: '1
   };

   lex_state_type state_ff, state_in;
   offset_type    offset_ff, offset_in;
   feed_type      f1, f2;
   offset_type    off1;
   logic          accept;
   bundle_type    bundle;

   // Character classes
   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return is_digit(c) || is_alpha(c) || c == "_";
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic offset_type sat_inc(offset_type v);
      return (v == OFFSET_MAX) ? v : offset_type'(v + 1'b1);
   endfunction

   function automatic rsp_type make_tok(logic [4:0] kind, logic [1:0] code,
                                        offset_type start, offset_type len);
      rsp_type t;
      t.token_kind   = kind;
      t.error_code   = code;
      t.token_start  = FIELD_BITS'(start);
      t.token_length = FIELD_BITS'(len);
      t.end_of_run   = 1'b0;
      return t;
   endfunction

   // Drop every keyword whose character at idx differs from c
   function automatic logic [KW_COUNT-1:0] update_alive(logic [KW_COUNT-1:0] alive,
                                                        logic [7:0] c, offset_type idx);
      logic [KW_COUNT-1:0] a;
      a = alive;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (idx >= offset_type'(KW_LEN[k]) || KW_TEXT[k][idx[2:0]] != c) begin
            a[k] = 1'b0;
         end
      end
      return a;
   endfunction

   // Identifier or keyword, decided by the surviving alive bit and length
   function automatic rsp_type flush_ident(lex_state_type s);
      logic [4:0] kind;
      kind = TK_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (s.alive[k] && s.len == offset_type'(KW_LEN[k])) begin
            kind = 5'(k);
         end
      end
      return make_tok(kind, ERR_NONE, s.start, s.len);
   endfunction

   // One lexing step on character c at offset pos; at most two tokens
   function automatic feed_type lex_feed(lex_state_type s, logic [7:0] c,
                                         offset_type pos);
      feed_type r;
      logic     used;
      logic     go;
      logic     has_t;
      rsp_type  t;
      r       = '0;
      r.st    = s;
      used    = 1'b0;
      go      = 1'b1;
      has_t   = 1'b0;
      t       = '0;

      // finish or extend the pending token
      unique case (s.mode)
         MODE_LT, MODE_COLON: begin
            if (c == "=") begin
               r.tok0    = make_tok((s.mode == MODE_LT) ? TK_LE : TK_ASSIGN, ERR_NONE,
                                    s.start, offset_type'(2));
               r.count   = 2'd1;
               r.st.mode = MODE_IDLE;
               used      = 1'b1;
            end else begin
               r.tok0    = make_tok(TK_ERROR, ERR_UNKNOWN, s.start, offset_type'(1));
               r.count   = 2'd1;
               r.st.mode = MODE_ERROR;
               go        = 1'b0;
            end
         end
         MODE_ZERO: begin
            if (is_word(c)) begin
               r.tok0    = make_tok(TK_ERROR, ERR_BAD_INT, s.start, offset_type'(2));
               r.count   = 2'd1;
               r.st.mode = MODE_ERROR;
               go        = 1'b0;
            end else begin
               r.tok0    = make_tok(TK_LITERAL, ERR_NONE, s.start, offset_type'(1));
               r.count   = 2'd1;
               r.st.mode = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c)) begin
               r.st.len = sat_inc(s.len);
               used     = 1'b1;
            end else begin
               r.tok0    = make_tok(TK_LITERAL, ERR_NONE, s.start, s.len);
               r.count   = 2'd1;
               r.st.mode = MODE_IDLE;
            end
         end
         MODE_IDENT: begin
            if (is_word(c)) begin
               r.st.alive = update_alive(s.alive, c, s.len);
               r.st.len   = sat_inc(s.len);
               used       = 1'b1;
            end else begin
               r.tok0    = flush_ident(s);
               r.count   = 2'd1;
               r.st.mode = MODE_IDLE;
            end
         end
         MODE_IDLE: begin
         end
         default: begin
            go = 1'b0;
         end
      endcase

      // start of a new token
      if (go && !used) begin
         priority if (c == 8'h00) begin
            t         = make_tok(TK_EOF, ERR_NONE, pos, '0);
            has_t     = 1'b1;
            r.st.mode = MODE_DONE;
         end else if (is_space(c)) begin
         end else if (c == ";") begin
            t     = make_tok(TK_SEMI, ERR_NONE, pos, offset_type'(1));
            has_t = 1'b1;
         end else if (c == "(") begin
            t     = make_tok(TK_LPAREN, ERR_NONE, pos, offset_type'(1));
            has_t = 1'b1;
         end else if (c == ")") begin
            t     = make_tok(TK_RPAREN, ERR_NONE, pos, offset_type'(1));
            has_t = 1'b1;
         end else if (c == "-") begin
            t     = make_tok(TK_MINUS, ERR_NONE, pos, offset_type'(1));
            has_t = 1'b1;
         end else if (c == "*") begin
            t     = make_tok(TK_STAR, ERR_NONE, pos, offset_type'(1));
            has_t = 1'b1;
         end else if (c == "<") begin
            r.st.mode  = MODE_LT;
            r.st.start = pos;
            r.st.len   = offset_type'(1);
         end else if (c == ":") begin
            r.st.mode  = MODE_COLON;
            r.st.start = pos;
            r.st.len   = offset_type'(1);
         end else if (c == "0") begin
            r.st.mode  = MODE_ZERO;
            r.st.start = pos;
            r.st.len   = offset_type'(1);
         end else if (is_digit(c)) begin
            r.st.mode  = MODE_NUMBER;
            r.st.start = pos;
            r.st.len   = offset_type'(1);
         end else if (is_alpha(c) || c == "_") begin
            r.st.mode  = MODE_IDENT;
            r.st.start = pos;
            r.st.len   = offset_type'(1);
            r.st.alive = update_alive('1, c, '0);
         end else begin
            t         = make_tok(TK_ERROR, ERR_UNKNOWN, pos, offset_type'(1));
            has_t     = 1'b1;
            r.st.mode = MODE_ERROR;
         end
      end

      if (has_t) begin
         if (r.count == 2'd0) begin
            r.tok0 = t;
         end else begin
            r.tok1 = t;
         end
         r.count = r.count + 2'd1;
      end
      return r;
   endfunction

   assign req_ready  = !q_status.full;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept && (bundle.count != 2'd0);
   assign push_data  = bundle;

   // Byte step, plus an implied NUL step on the last byte of a source
   always_comb begin
      f1   = lex_feed(state_ff, req_data.source_byte, offset_ff);
      off1 = (state_ff.mode != MODE_ERROR && state_ff.mode != MODE_DONE &&
              f1.st.mode != MODE_DONE) ? sat_inc(offset_ff) : offset_ff;
      f2   = lex_feed(f1.st, 8'h00, off1);
      bundle = '0;
      if (req_data.last_byte) begin
         state_in  = RESET_STATE;
         offset_in = '0;
         unique case (f1.count)
            2'd0: begin
               bundle.tok[0] = f2.tok0;
               bundle.tok[1] = f2.tok1;
               bundle.count  = f2.count;
            end
            2'd1: begin
               bundle.tok[0] = f1.tok0;
               bundle.tok[1] = f2.tok0;
               bundle.tok[2] = f2.tok1;
               bundle.count  = 2'd1 + f2.count;
            end
            default: begin
               bundle.tok[0] = f1.tok0;
               bundle.tok[1] = f1.tok1;
               bundle.tok[2] = f2.tok0;
               bundle.count  = (f2.count == 2'd0) ? 2'd2 : 2'd3;
            end
         endcase
      end else begin
         state_in      = f1.st;
         offset_in     = off1;
         bundle.tok[0] = f1.tok0;
         bundle.tok[1] = f1.tok1;
         bundle.count  = f1.count;
      end
   end

   // Lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= RESET_STATE;
         offset_ff <= '0;
      end else if (accept) begin
         state_ff  <= state_in;
         offset_ff <= offset_in;
      end
   end

endmodule

@@ rtl/core/kls_queue.sv @@
// ----------------------------------------------------------------------------
// kls_queue
// Short queue of token bundles between the lexer front and the output back.
// ----------------------------------------------------------------------------
module kls_queue import kls_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  bundle_type       push_data,
   input  logic             pop,
   output bundle_type       pop_data,
   output queue_status_type status
);

   localparam logic [QPTR_BITS-1:0] LAST_SLOT = QPTR_BITS'(QUEUE_DEPTH - 1);

   bundle_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign status.full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entries_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/kls_back.sv @@
// ----------------------------------------------------------------------------
// kls_back
// Output stage: unpacks each bundle and sends its tokens one word per cycle
// while rsp_ready is high, marking the last token of each source byte.
// ----------------------------------------------------------------------------
module kls_back import kls_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  bundle_type       pop_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   bundle_type cur_ff;
   logic [1:0] idx_ff;
   logic       busy_ff;
   logic       last_tok;
   logic       take;
   logic       done;

   assign last_tok  = (idx_ff == cur_ff.count - 2'd1);
   assign take      = rsp_valid && rsp_ready;
   assign done      = !busy_ff || (take && last_tok);
   assign pop       = done && !q_status.empty;
   assign rsp_valid = busy_ff;

   // Current token with its end-of-run mark
   always_comb begin
      rsp_data            = cur_ff.tok[idx_ff];
      rsp_data.end_of_run = last_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (pop) begin
         cur_ff  <= pop_data;
         idx_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (take) begin
         idx_ff  <= idx_ff + 2'd1;
      end
   end

endmodule

@@ rtl/core/keyword_lexer_stream.sv @@
// ----------------------------------------------------------------------------
// keyword_lexer_stream
// Streaming lexer: source bytes in, tokens (kind, start, length) out.
//
//   Channel  Ports       Word      Role
//   req      req_*       req_type  one source byte plus last-byte mark
//   rsp      rsp_*       rsp_type  one token, end_of_run on the last per byte
//
// One byte is lexed per cycle; a byte yields zero to three tokens.
// Tokens leave at one word per cycle while rsp_ready is high, so the sustained
// input rate is one byte per cycle while bytes average one token or fewer.
// The front reaches the back through a four-bundle queue; the front stalls
// only when that queue is full; tokens are registered in the queue and the back.
// Synchronous reset returns the lexer to idle with offsets at zero.
// ----------------------------------------------------------------------------
module keyword_lexer_stream import kls_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   queue_status_type q_status;
   logic             push_valid;
   bundle_type       push_data;
   logic             pop;
   bundle_type       pop_data;

   kls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   kls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (pop_data),
      .status     (q_status)
   );

   kls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/kls_checker.sv @@
// ----------------------------------------------------------------------------
// kls_checker
// Port-level checks on the token stream of keyword_lexer_stream.
// ----------------------------------------------------------------------------
module kls_checker import kls_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // Error code set exactly on error tokens
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.error_code != ERR_NONE) ==
                     (rsp_data.token_kind == TK_ERROR)))
      else $error("error code and token kind disagree");

   // End token is empty and closes its byte's run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == TK_EOF |->
         rsp_data.token_length == '0 && rsp_data.end_of_run)
      else $error("bad end token");

   // Nothing follows an error within the same byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == TK_ERROR |-> rsp_data.end_of_run)
      else $error("error token not last of run");

   // Two-character symbols have length two
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_kind == TK_LE || rsp_data.token_kind == TK_ASSIGN) |->
         rsp_data.token_length == FIELD_BITS'(2))
      else $error("bad length on two-character symbol");

endmodule

bind keyword_lexer_stream kls_checker u_checker (.*);
